// ===== hdl/sobel_edge_magnitude_assert.svh =====
// Assertion macros for the edge magnitude block, empty in synthesis.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk_i, off during reset.
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, clocked on clk_i, off during reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/sem_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude block.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int GRAY_W     = 8;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 20;
  localparam int SUM_W      = 21;
  localparam int ROW_W      = 12;
  localparam int HCMP_W     = 13;
  localparam int OCOL_W     = 10;
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;
  localparam int SAT_LEVEL  = 255;
  localparam int SAT_SQ     = SAT_LEVEL * SAT_LEVEL;

  // Fixed-point gray weights, unsigned Q0.16, summing to 65536.
  localparam int W_RED   = 19595;
  localparam int W_GREEN = 38470;
  localparam int W_BLUE  = 7471;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic valid;
  } sqrt_stat_t;

endpackage

// ===== hdl/sem_line_buf.sv =====
// Two gray line stores in one memory, read-modify-write with a fill count.
`timescale 1ns / 1ps
module sem_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]    addr_i,
  input  logic                            wr_en_i,
  input  logic [sem_pkg::GRAY_W-1:0]      gray_i,
  output logic [sem_pkg::GRAY_W-1:0]      upper_o,
  output logic [sem_pkg::GRAY_W-1:0]      middle_o
);
  import sem_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // Entry: upper line in the high byte, middle line in the low byte.
  logic [2*GRAY_W-1:0] mem [MAX_WIDTH];
  logic [2*GRAY_W-1:0] rd_data_q;
  logic [AW-1:0]       addr_q;
  logic                hit_q;
  logic [AW:0]         fill_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[addr_i];
    end
    if (wr_en_i) begin
      mem[addr_q] <= {middle_o, gray_i};
    end
  end

  // Columns are visited in order from zero, so entries below the fill count are written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      hit_q  <= 1'b0;
      addr_q <= '0;
    end else begin
      if (rd_en_i) begin
        addr_q <= addr_i;
        hit_q  <= ({1'b0, addr_i} < fill_q);
      end
      if (wr_en_i && ({1'b0, addr_q} == fill_q)) begin
        fill_q <= fill_q + (AW+1)'(1);
      end
    end
  end

  assign upper_o  = hit_q ? rd_data_q[2*GRAY_W-1:GRAY_W] : '0;
  assign middle_o = hit_q ? rd_data_q[GRAY_W-1:0] : '0;

endmodule

// ===== hdl/sem_isqrt.sv =====
// Bit-per-cycle floor square root, saturated at the top gray level.
`timescale 1ns / 1ps
module sem_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sem_pkg::SUM_W-1:0]   radicand_i,
  output sem_pkg::sqrt_stat_t         stat_o,
  output logic [sem_pkg::GRAY_W-1:0]  root_o
);
  import sem_pkg::*;

  logic [2*GRAY_W-1:0] rad_q;
  logic [GRAY_W-1:0]   root_q;
  logic [GRAY_W-1:0]   bit_q;
  logic                busy_q;
  logic                valid_q;
  logic [GRAY_W-1:0]   trial;
  logic [2*GRAY_W-1:0] trial_sq;

  assign trial    = root_q | bit_q;
  assign trial_sq = (2*GRAY_W)'(trial) * (2*GRAY_W)'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      root_q  <= '0;
      bit_q   <= '0;
      rad_q   <= '0;
    end else if (start_i) begin
      if (radicand_i >= SUM_W'(SAT_SQ)) begin
        // Saturate at once.
        root_q  <= GRAY_W'(SAT_LEVEL);
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end else begin
        rad_q   <= radicand_i[2*GRAY_W-1:0];
        root_q  <= '0;
        bit_q   <= {1'b1, {(GRAY_W-1){1'b0}}};
        busy_q  <= 1'b1;
        valid_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (trial_sq <= rad_q) begin
        root_q <= trial;
      end
      bit_q <= bit_q >> 1;
      if (bit_q[0]) begin
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.valid = valid_q;
  assign root_o       = root_q;

endmodule

// ===== hdl/sobel_edge_magnitude.sv =====
// Sobel edge magnitude top level: gray conversion, line stores, window and control.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_assert.svh"
// Takes RGB pixels in raster order, one transaction at a time, converts each to
// 8-bit gray and emits the saturated Sobel magnitude for interior pixels only,
// with column, row and end-of-row / end-of-frame marks. A pixel that yields no
// result (first two rows or columns) takes one synchronous read of the line
// store memory, then the write-back. An interior pixel passes the read,
// gradient, squares and sum stages, then the 8-step bit-serial square root,
// which is skipped when the magnitude saturates, and the output load. A result
// sits in the output register while the next pixel is taken; a stalled output
// holds the block only when a second result is ready. Line stores need no
// clearing after reset: a fill count masks unwritten columns to zero.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [23:0]                       pixel_rgb_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sem_pkg::GRAY_W-1:0]        edge_level_o,
  output logic [sem_pkg::OCOL_W-1:0]        out_column_o,
  output logic [sem_pkg::ROW_W-1:0]         out_row_o,
  output logic                              row_end_o,
  output logic                              frame_end_o,
  input  logic                              cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sem_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WCMP_W  = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int XW      = (AW > OCOL_W) ? AW : OCOL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_GRAD,
    S_SQR,
    S_SUM,
    S_ROOT
  } state_e;

  state_e state_q;

  logic [10:0]         image_width_q;
  logic [12:0]         image_height_q;
  logic [AW-1:0]       col_cnt_q;
  logic [ROW_W-1:0]    row_cnt_q;

  logic [23:0]         pix_q;
  logic                interior_q;
  logic [OCOL_W-1:0]   ocol_q;
  logic [ROW_W-1:0]    orow_q;
  logic                rend_q;
  logic                fend_q;
  logic [GRAY_W-1:0]   win_q [9];
  logic signed [GRAD_W-1:0] gx_q;
  logic signed [GRAD_W-1:0] gy_q;
  logic [SQ_W-1:0]     sqx_q;
  logic [SQ_W-1:0]     sqy_q;

  logic                out_valid_q;
  logic [GRAY_W-1:0]   edge_q;
  logic [OCOL_W-1:0]   out_col_q;
  logic [ROW_W-1:0]    out_row_q;
  logic                out_rend_q;
  logic                out_fend_q;

  logic                accept;
  logic                out_free;
  logic                load_out;
  logic [WCMP_W-1:0]   w_raw;
  logic [WCMP_W-1:0]   w_eff;
  logic [HCMP_W-1:0]   h_raw;
  logic [HCMP_W-1:0]   h_eff;
  logic                last_col;
  logic                last_row;
  logic [XW-1:0]       ocol_ext;
  logic [23:0]         gray_acc;
  logic [GRAY_W-1:0]   gray;
  logic [GRAY_W-1:0]   upper;
  logic [GRAY_W-1:0]   middle;
  logic [GRAD_W-1:0]   gx_pos;
  logic [GRAD_W-1:0]   gx_neg;
  logic [GRAD_W-1:0]   gy_pos;
  logic [GRAD_W-1:0]   gy_neg;
  logic signed [2*GRAD_W-1:0] prod_x;
  logic signed [2*GRAD_W-1:0] prod_y;
  logic [SUM_W-1:0]    radicand;
  sqrt_stat_t          sq_stat;
  logic [GRAY_W-1:0]   root;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_ROOT) && sq_stat.valid && out_free;

  // Clamp frame size to the supported range.
  assign w_raw = WCMP_W'(image_width_q);
  assign w_eff = (w_raw < WCMP_W'(MIN_DIM)) ? WCMP_W'(MIN_DIM) :
                 (w_raw > WCMP_W'(MAX_WIDTH)) ? WCMP_W'(MAX_WIDTH) : w_raw;
  assign h_raw = image_height_q;
  assign h_eff = (h_raw < HCMP_W'(MIN_DIM)) ? HCMP_W'(MIN_DIM) :
                 (h_raw > HCMP_W'(MAX_HEIGHT)) ? HCMP_W'(MAX_HEIGHT) : h_raw;
  assign last_col = (WCMP_W'(col_cnt_q) + WCMP_W'(1)) >= w_eff;
  assign last_row = (HCMP_W'(row_cnt_q) + HCMP_W'(1)) >= h_eff;
  assign ocol_ext = XW'(col_cnt_q) - XW'(1);

  // Gray conversion from the held pixel.
  assign gray_acc = 24'(W_RED)   * 24'(pix_q[23:16])
                  + 24'(W_GREEN) * 24'(pix_q[15:8])
                  + 24'(W_BLUE)  * 24'(pix_q[7:0]);
  assign gray = gray_acc[23:16];

  sem_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .addr_i   (col_cnt_q),
    .wr_en_i  (state_q == S_RD),
    .gray_i   (gray),
    .upper_o  (upper),
    .middle_o (middle)
  );

  // Kernel sums on the window, each side nonnegative and below 1024.
  assign gx_pos = GRAD_W'(win_q[2]) + GRAD_W'({win_q[5], 1'b0}) + GRAD_W'(win_q[8]);
  assign gx_neg = GRAD_W'(win_q[0]) + GRAD_W'({win_q[3], 1'b0}) + GRAD_W'(win_q[6]);
  assign gy_pos = GRAD_W'(win_q[6]) + GRAD_W'({win_q[7], 1'b0}) + GRAD_W'(win_q[8]);
  assign gy_neg = GRAD_W'(win_q[0]) + GRAD_W'({win_q[1], 1'b0}) + GRAD_W'(win_q[2]);

  assign prod_x   = (2*GRAD_W)'(gx_q) * (2*GRAD_W)'(gx_q);
  assign prod_y   = (2*GRAD_W)'(gy_q) * (2*GRAD_W)'(gy_q);
  assign radicand = SUM_W'(sqx_q) + SUM_W'(sqy_q);

  sem_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SUM),
    .radicand_i (radicand),
    .stat_o     (sq_stat),
    .root_o     (root)
  );

  // Configuration and position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 11'd640;
      image_height_q <= 13'd480;
      col_cnt_q      <= '0;
      row_cnt_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  image_width_q  <= cfg_data_i[10:0];
          CFG_HEIGHT: image_height_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (accept) begin
        if (last_col) begin
          col_cnt_q <= '0;
          row_cnt_q <= last_row ? '0 : row_cnt_q + ROW_W'(1);
        end else begin
          col_cnt_q <= col_cnt_q + AW'(1);
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q      <= pixel_rgb_i;
      interior_q <= (col_cnt_q >= AW'(2)) && (row_cnt_q >= ROW_W'(2));
      ocol_q     <= ocol_ext[OCOL_W-1:0];
      orow_q     <= row_cnt_q - ROW_W'(1);
      rend_q     <= last_col;
      fend_q     <= last_col && last_row;
    end
    if (state_q == S_RD) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k*3]   <= win_q[k*3+1];
        win_q[k*3+1] <= win_q[k*3+2];
      end
      win_q[2] <= upper;
      win_q[5] <= middle;
      win_q[8] <= gray;
    end
    if (state_q == S_GRAD) begin
      gx_q <= $signed(gx_pos) - $signed(gx_neg);
      gy_q <= $signed(gy_pos) - $signed(gy_neg);
    end
    if (state_q == S_SQR) begin
      sqx_q <= prod_x[SQ_W-1:0];
      sqy_q <= prod_y[SQ_W-1:0];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      edge_q      <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_rend_q  <= 1'b0;
      out_fend_q  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
        edge_q      <= root;
        out_col_q   <= ocol_q;
        out_row_q   <= orow_q;
        out_rend_q  <= rend_q;
        out_fend_q  <= fend_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (accept) state_q <= S_RD;
        S_RD:   state_q <= interior_q ? S_GRAD : S_IDLE;
        S_GRAD: state_q <= S_SQR;
        S_SQR:  state_q <= S_SUM;
        S_SUM:  state_q <= S_ROOT;
        S_ROOT: if (load_out) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_level_o = edge_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign row_end_o    = out_rend_q;
  assign frame_end_o  = out_fend_q;

  `SEM_ASSERT_NEXT(a_busy_after_accept, accept, in_stall_o, "pixel taken but block not busy")
  `SEM_ASSERT_IMPL(a_frame_end_on_row_end, out_valid_o && frame_end_o, row_end_o, "frame end without row end")
  `SEM_ASSERT_IMPL(a_col_in_range, 1'b1, {1'b0, col_cnt_q} < (AW+1)'(MAX_WIDTH), "column counter past line store depth")
  `SEM_ASSERT_IMPL(a_idle_root_quiet, state_q == S_IDLE, !sq_stat.busy, "square root busy while idle")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Sobel edge magnitude block.
`timescale 1ns / 1ps
module tb_top;
  import sem_pkg::*;

  localparam int unsigned LINE_MAX      = 1024;
  localparam int unsigned ROWS_MAX      = 4096;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned GRAY_WT_R     = 19595;
  localparam int unsigned GRAY_WT_G     = 38470;
  localparam int unsigned GRAY_WT_B     = 7471;
  localparam int unsigned LEVEL_CAP     = 255;

  typedef enum logic [1:0] {STEP_PIXEL, STEP_CONFIG, STEP_DRAIN, STEP_MODE} step_kind_e;
  typedef enum logic [1:0] {TEX_NOISE, TEX_SMOOTH, TEX_BINARY, TEX_PRIMARY} texture_e;

  typedef struct {
    step_kind_e            kind;
    logic [23:0]           rgb;
    cfg_idx_e              index;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           send_pct;
    int unsigned           recv_pct;
  } stim_step_t;

  typedef struct packed {
    logic [GRAY_W-1:0] level;
    logic [OCOL_W-1:0] column;
    logic [ROW_W-1:0]  row;
    logic              row_end;
    logic              frame_end;
  } edge_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [23:0]           pixel_rgb_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [GRAY_W-1:0]     edge_level_o;
  logic [OCOL_W-1:0]     out_column_o;
  logic [ROW_W-1:0]      out_row_o;
  logic                  row_end_o;
  logic                  frame_end_o;
  logic                  cfg_we_i    = 1'b0;
  cfg_idx_e              cfg_index_i = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  sobel_edge_magnitude #(
    .MAX_WIDTH(LINE_MAX)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_rgb_i (pixel_rgb_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .edge_level_o(edge_level_o),
    .out_column_o(out_column_o),
    .out_row_o   (out_row_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and pending expectations
  stim_step_t   step_q[$];
  edge_result_t pending_edges[$];

  // Edge predictor state
  logic [GRAY_W-1:0] gray_line_two[LINE_MAX];
  logic [GRAY_W-1:0] gray_line_one[LINE_MAX];
  logic [GRAY_W-1:0] gray_win[9];
  logic [10:0]       width_reg  = 11'd640;
  logic [12:0]       height_reg = 13'd480;
  int unsigned       pos_col    = 0;
  int unsigned       pos_row    = 0;

  // Stimulus builder's view of the frame position
  int unsigned gen_col       = 0;
  int unsigned gen_row       = 0;
  int unsigned gen_w         = 640;
  int unsigned gen_h         = 480;
  int unsigned pixels_queued = 0;

  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  logic        pix_accepted    = 1'b0;
  int unsigned quiet_cycles    = 0;
  int unsigned cycle_count     = 0;
  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned saturated_count = 0;
  int unsigned pixels_sent     = 0;
  int unsigned cfg_writes      = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [GRAY_W-1:0] root_capped(int unsigned sq_sum);
    int unsigned root;
    int unsigned trial;
    root = 0;
    if (sq_sum >= LEVEL_CAP * LEVEL_CAP) return LEVEL_CAP[GRAY_W-1:0];
    for (int b = 7; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= sq_sum) root = trial;
    end
    return root[GRAY_W-1:0];
  endfunction

  // Gray-convert one pixel, slide the window and queue the magnitude it completes.
  task automatic compute_edge(input logic [23:0] rgb);
    int unsigned  wdt, hgt, c, r, gray, sq_sum;
    int           gx, gy;
    logic         last_col, last_row;
    edge_result_t res;
    wdt  = clamp_dim(width_reg, LINE_MAX);
    hgt  = clamp_dim(height_reg, ROWS_MAX);
    c    = pos_col % LINE_MAX;
    r    = pos_row;
    gray = (GRAY_WT_R * rgb[23:16] + GRAY_WT_G * rgb[15:8] + GRAY_WT_B * rgb[7:0]) >> 16;
    for (int k = 0; k < 3; k++) begin
      gray_win[k*3]   = gray_win[k*3+1];
      gray_win[k*3+1] = gray_win[k*3+2];
    end
    gray_win[2] = gray_line_two[c];
    gray_win[5] = gray_line_one[c];
    gray_win[8] = gray[GRAY_W-1:0];
    gray_line_two[c] = gray_line_one[c];
    gray_line_one[c] = gray[GRAY_W-1:0];
    last_col = (c + 1 >= wdt);
    last_row = (r + 1 >= hgt);
    if (c >= 2 && r >= 2) begin
      gx = (int'(gray_win[2]) + 2 * int'(gray_win[5]) + int'(gray_win[8]))
         - (int'(gray_win[0]) + 2 * int'(gray_win[3]) + int'(gray_win[6]));
      gy = (int'(gray_win[6]) + 2 * int'(gray_win[7]) + int'(gray_win[8]))
         - (int'(gray_win[0]) + 2 * int'(gray_win[1]) + int'(gray_win[2]));
      sq_sum        = gx * gx + gy * gy;
      res.level     = root_capped(sq_sum);
      res.column    = OCOL_W'(c - 1);
      res.row       = ROW_W'(r - 1);
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      pending_edges.push_back(res);
    end
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endtask

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic block_idle();
    return pending_edges.size() == 0 && quiet_cycles >= SETTLE_CYCLES;
  endfunction

  // Stimulus builders
  function automatic void push_pixel(logic [23:0] rgb);
    stim_step_t s;
    s = '{kind: STEP_PIXEL, rgb: rgb, index: CFG_WIDTH, data: '0, send_pct: 0, recv_pct: 0};
    step_q.push_back(s);
    pixels_queued++;
    if (gen_col + 1 >= gen_w) begin
      gen_col = 0;
      gen_row = (gen_row + 1 >= gen_h) ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
  endfunction

  function automatic void push_config(cfg_idx_e idx, int unsigned value);
    stim_step_t s;
    s = '{kind: STEP_CONFIG, rgb: '0, index: idx, data: value[CFG_DATA_W-1:0],
          send_pct: 0, recv_pct: 0};
    step_q.push_back(s);
    if (idx == CFG_WIDTH) gen_w = clamp_dim(value & 32'h7FF, LINE_MAX);
    else gen_h = clamp_dim(value & 32'h1FFF, ROWS_MAX);
  endfunction

  function automatic void push_drain();
    stim_step_t s;
    s = '{kind: STEP_DRAIN, rgb: '0, index: CFG_WIDTH, data: '0, send_pct: 0, recv_pct: 0};
    step_q.push_back(s);
  endfunction

  function automatic void push_mode(int unsigned send_pct, int unsigned recv_pct);
    stim_step_t s;
    s = '{kind: STEP_MODE, rgb: '0, index: CFG_WIDTH, data: '0,
          send_pct: send_pct, recv_pct: recv_pct};
    step_q.push_back(s);
  endfunction

  function automatic logic [23:0] texture_pixel(texture_e tex, logic [7:0] base);
    logic [7:0] red, grn, blu;
    case (tex)
      TEX_SMOOTH: begin
        red = base + 8'($urandom_range(0, 6));
        grn = base + 8'($urandom_range(0, 6));
        blu = base + 8'($urandom_range(0, 6));
      end
      TEX_BINARY: begin
        red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        grn = red;
        blu = red;
      end
      TEX_PRIMARY: begin
        red = {8{1'($urandom_range(0, 1))}};
        grn = {8{1'($urandom_range(0, 1))}};
        blu = {8{1'($urandom_range(0, 1))}};
      end
      default: return 24'($urandom);
    endcase
    return {red, grn, blu};
  endfunction

  // Fill pixels until the position wraps back to the top left corner.
  function automatic void push_frame_rest(texture_e tex, logic [7:0] base);
    do push_pixel(texture_pixel(tex, base));
    while (gen_col != 0 || gen_row != 0);
  endfunction

  function automatic int unsigned random_width();
    int unsigned v;
    case ($urandom_range(0, 7))
      0:       v = $urandom_range(0, 2);
      1:       v = $urandom_range(13, 40);
      default: v = $urandom_range(3, 12);
    endcase
    // upper data bits are outside the width register
    return ($urandom_range(0, 3) << 11) | v;
  endfunction

  function automatic int unsigned random_height();
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 7);
  endfunction

  task automatic push_random_phase(int unsigned send_pct, int unsigned recv_pct,
                                   int unsigned budget);
    int unsigned start, cut;
    texture_e    tex;
    logic [7:0]  base;
    push_mode(send_pct, recv_pct);
    start = pixels_queued;
    while (pixels_queued - start < budget) begin
      tex  = texture_e'($urandom_range(0, 3));
      base = 8'($urandom_range(0, 249));
      if ($urandom_range(0, 9) == 0) push_drain();
      if ($urandom_range(0, 1) == 0) begin
        push_config(CFG_WIDTH, random_width());
        push_config(CFG_HEIGHT, random_height());
      end
      // broken frame: rewrite a register partway through
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, gen_w * gen_h);
        repeat (cut) push_pixel(texture_pixel(tex, base));
        if ($urandom_range(0, 1)) push_config(CFG_WIDTH, random_width());
        else push_config(CFG_HEIGHT, random_height());
      end
      push_frame_rest(tex, base);
    end
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    stim_step_t head;
    logic       drive_valid;
    logic       drive_we;
    if (rst_ni) begin
      drive_we    = 1'b0;
      drive_valid = in_valid_i && !pix_accepted;
      if (!drive_valid && step_q.size() != 0) begin
        head = step_q[0];
        case (head.kind)
          STEP_PIXEL: begin
            if ($urandom_range(0, 99) >= send_idle_pct) begin
              pixel_rgb_i <= head.rgb;
              drive_valid = 1'b1;
              void'(step_q.pop_front());
              pixels_sent++;
            end
          end
          STEP_CONFIG: begin
            if (block_idle()) begin
              cfg_index_i <= head.index;
              cfg_data_i  <= head.data;
              drive_we    = 1'b1;
              void'(step_q.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (block_idle()) void'(step_q.pop_front());
          end
          default: begin
            send_idle_pct = head.send_pct;
            recv_idle_pct = head.recv_pct;
            void'(step_q.pop_front());
          end
        endcase
      end
      in_valid_i  <= drive_valid;
      cfg_we_i    <= drive_we;
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: predict on accepted pixels, check accepted results
  always @(posedge clk_i) begin
    edge_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_edges.size());
      $display("Test completed with failures");
      $finish;
    end else if (rst_ni) begin
      pix_accepted <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        compute_edge(pixel_rgb_i);
        quiet_cycles <= 0;
      end else if (quiet_cycles < SETTLE_CYCLES) begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (cfg_we_i) begin
        cfg_writes++;
        case (cfg_index_i)
          CFG_WIDTH:  width_reg  = cfg_data_i[10:0];
          CFG_HEIGHT: height_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_edges.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual level %0d column %0d row %0d",
                   $time, edge_level_o, out_column_o, out_row_o);
          mismatch_count++;
        end else begin
          want = pending_edges.pop_front();
          check_field("edge_level", want.level, edge_level_o);
          check_field("out_column", want.column, out_column_o);
          check_field("out_row", want.row, out_row_o);
          check_field("row_end", want.row_end, row_end_o);
          check_field("frame_end", want.frame_end, frame_end_o);
          results_checked++;
          if (want.level == LEVEL_CAP[GRAY_W-1:0]) saturated_count++;
        end
      end
    end
  end

  initial begin
    logic [23:0] directed_px[18];
    texture_e    tex;
    directed_px = '{
      // hard vertical edge with primaries on the dark side: saturates
      24'h000000, 24'hFF0000, 24'hFFFFFF,
      24'h0000FF, 24'h00FF00, 24'hFFFFFF,
      24'h000000, 24'hFFFF00, 24'hFFFFFF,
      // gentle ramp: small magnitude
      24'h0A0A0A, 24'h0C0C0C, 24'h0E0E0E,
      24'h0A0B0A, 24'h0C0D0C, 24'h0E0F0E,
      24'h0B0B0B, 24'h0D0D0D, 24'h0F0F0F
    };
    for (int i = 0; i < LINE_MAX; i++) begin
      gray_line_two[i] = '0;
      gray_line_one[i] = '0;
    end
    for (int i = 0; i < 9; i++) gray_win[i] = '0;

    push_mode(29, 51);
    push_config(CFG_WIDTH, MIN_DIM);
    push_config(CFG_HEIGHT, MIN_DIM);
    foreach (directed_px[i]) push_pixel(directed_px[i]);
    push_drain();
    push_random_phase(29, 51, 300);
    push_random_phase(51, 29, 300);

    push_mode(0, 0);
    // widest line: one full line, then into the next
    push_config(CFG_WIDTH, LINE_MAX);
    push_config(CFG_HEIGHT, MIN_DIM);
    repeat (LINE_MAX + 2) begin
      tex = texture_e'($urandom_range(0, 3));
      push_pixel(texture_pixel(tex, 8'($urandom_range(0, 249))));
    end
    // width above range, then shrink below the current column
    push_config(CFG_WIDTH, 32'h1FFF);
    repeat (6) push_pixel(texture_pixel(TEX_NOISE, 8'd0));
    push_config(CFG_WIDTH, 4);
    push_frame_rest(TEX_NOISE, 8'd0);
    // tallest frame, then shrink height below the current row
    push_config(CFG_WIDTH, MIN_DIM);
    push_config(CFG_HEIGHT, ROWS_MAX);
    repeat (MIN_DIM * 20) push_pixel(texture_pixel(TEX_PRIMARY, 8'd0));
    push_config(CFG_HEIGHT, 32'h1FFF);
    repeat (MIN_DIM * 20) push_pixel(texture_pixel(TEX_SMOOTH, 8'd100));
    push_config(CFG_HEIGHT, 5);
    push_frame_rest(TEX_BINARY, 8'd0);
    // both registers below range
    push_config(CFG_WIDTH, 0);
    push_config(CFG_HEIGHT, 0);
    push_frame_rest(TEX_NOISE, 8'd0);
    push_random_phase(0, 0, 200);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (step_q.size() != 0 || in_valid_i || pending_edges.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d pixels and %0d register writes over three idle profiles;",
             pixels_sent, cfg_writes);
    $display("%0d edge results checked, %0d of them saturated.",
             results_checked, saturated_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sobel_edge_magnitude.f =====
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_line_buf.sv
hdl/sem_isqrt.sv
hdl/sobel_edge_magnitude.sv
tb/sv/tb_top.sv
